// File: hdl/iac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iac_pkg;

  // Field widths
  localparam int CH_W        = 8;   // one 8-bit color channel or alpha
  localparam int COLOR_W     = 16;  // RGB565
  localparam int EDGE_W      = 10;  // left_pos / top_pos
  localparam int DIM_W       = 9;   // icon_width / icon_height
  localparam int POS_W       = 11;  // pos_x / pos_y
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_ICON_DIM_DEF = 256;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_POS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_POS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ICON_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ICON_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCUS_MODE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TINT_COLOR  = 3'd5;

  // Register reset values
  localparam logic [EDGE_W-1:0]  LEFT_POS_RST    = '0;
  localparam logic [EDGE_W-1:0]  TOP_POS_RST     = '0;
  localparam logic [DIM_W-1:0]   ICON_WIDTH_RST  = 9'd32;
  localparam logic [DIM_W-1:0]   ICON_HEIGHT_RST = 9'd32;
  localparam logic               FOCUS_MODE_RST  = 1'b0;
  localparam logic [COLOR_W-1:0] TINT_COLOR_RST  = 16'hFFE0;

  // Alpha codes
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Packed 565 tint blend: g in the upper half, r and b in the lower half
  localparam logic [31:0] TINT_MASK  = 32'h07E0F81F;
  localparam int          TINT_SHIFT = 5;   // weight is over 32

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             icon_done;
  } pos_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               write_enable;
  } mix_t;

endpackage

`default_nettype wire

// File: hdl/iac_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Icon pixel request channel
interface iac_in_if import iac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    src_blue;
  logic [CH_W-1:0]    src_green;
  logic [CH_W-1:0]    src_red;
  logic [CH_W-1:0]    src_alpha;
  logic [COLOR_W-1:0] back_pixel;

  modport source (output valid, src_blue, src_green, src_red, src_alpha, back_pixel,
                  input ready);
  modport sink   (input valid, src_blue, src_green, src_red, src_alpha, back_pixel,
                  output ready);
endinterface

// Composited pixel request channel
interface iac_out_if import iac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [COLOR_W-1:0] out_color;
  logic               write_enable;
  logic               icon_done;

  modport source (output valid, pos_x, pos_y, out_color, write_enable, icon_done,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, out_color, write_enable, icon_done,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/icon_alpha_composite_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      payload
// in_chan   in   valid/ready    src_blue, src_green, src_red, src_alpha, back_pixel
// out_chan  out  valid/ready    pos_x, pos_y, out_color, write_enable, icon_done
// cfg       in   cfg_we         cfg_index, cfg_data (no wait, no read-back)
//
// One request per clock sustained while out_chan.ready stays high; a request passes
// the input, alpha mix and output registers in turn before out_chan.valid rises for it.
// Stages: input register (position latched), alpha mix register, tint/output register.
// Each stage refills as soon as it empties, so a stalled output only holds
// the stages behind it once they are full.
// rst (synchronous) clears valids, counters and configuration registers to their defaults.
module icon_alpha_composite_core import iac_pkg::*; #(
  parameter int MAX_ICON_DIM = MAX_ICON_DIM_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  iac_in_if.sink                      in_chan,
  iac_out_if.source                   out_chan
);

  // configuration registers
  logic [EDGE_W-1:0]  left_pos;
  logic [EDGE_W-1:0]  top_pos;
  logic [DIM_W-1:0]   icon_width;
  logic [DIM_W-1:0]   icon_height;
  logic               focus_mode;
  logic [COLOR_W-1:0] tint_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pos    <= LEFT_POS_RST;
      top_pos     <= TOP_POS_RST;
      icon_width  <= ICON_WIDTH_RST;
      icon_height <= ICON_HEIGHT_RST;
      focus_mode  <= FOCUS_MODE_RST;
      tint_color  <= TINT_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_POS:    left_pos    <= cfg_data[EDGE_W-1:0];
        REG_TOP_POS:     top_pos     <= cfg_data[EDGE_W-1:0];
        REG_ICON_WIDTH:  icon_width  <= cfg_data[DIM_W-1:0];
        REG_ICON_HEIGHT: icon_height <= cfg_data[DIM_W-1:0];
        REG_FOCUS_MODE:  focus_mode  <= cfg_data[0];
        REG_TINT_COLOR:  tint_color  <= cfg_data[COLOR_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // stage handshake: a stage loads when empty or when the next one loads
  logic out_valid;
  logic s1_valid;
  logic s2_valid;
  logic out_load;
  logic s2_load;
  logic s1_load;
  logic in_accept;

  assign out_load  = !out_valid || out_chan.ready;
  assign s2_load   = !s2_valid || out_load;
  assign s1_load   = !s1_valid || s2_load;
  assign in_accept = in_chan.valid && s1_load;

  assign in_chan.ready = s1_load;

  // counters advance on every accepted request
  pos_t cur_pos;

  iac_position #(
    .MAX_ICON_DIM (MAX_ICON_DIM)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .advance     (in_accept),
    .left_pos    (left_pos),
    .top_pos     (top_pos),
    .icon_width  (icon_width),
    .icon_height (icon_height),
    .pos         (cur_pos)
  );

  // stage 1: accepted pixel and its position
  logic [CH_W-1:0]    s1_blue;
  logic [CH_W-1:0]    s1_green;
  logic [CH_W-1:0]    s1_red;
  logic [CH_W-1:0]    s1_alpha;
  logic [COLOR_W-1:0] s1_back;
  pos_t               s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_chan.valid;
    end
    if (in_accept) begin
      s1_blue  <= in_chan.src_blue;
      s1_green <= in_chan.src_green;
      s1_red   <= in_chan.src_red;
      s1_alpha <= in_chan.src_alpha;
      s1_back  <= in_chan.back_pixel;
      s1_pos   <= cur_pos;
    end
  end

  // stage 2: alpha mix result
  mix_t s1_mix;
  mix_t s2_mix;
  pos_t s2_pos;

  iac_mix u_mix (
    .src_blue   (s1_blue),
    .src_green  (s1_green),
    .src_red    (s1_red),
    .src_alpha  (s1_alpha),
    .back_pixel (s1_back),
    .mix        (s1_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
    if (s2_load) begin
      s2_mix <= s1_mix;
      s2_pos <= s1_pos;
    end
  end

  // output register: focus tint only on written pixels
  logic [COLOR_W-1:0] s2_tinted;
  logic [COLOR_W-1:0] s2_color;
  mix_t               out_mix;
  pos_t               out_pos;

  iac_tint u_tint (
    .base   (s2_mix.color),
    .tint   (tint_color),
    .tinted (s2_tinted)
  );

  assign s2_color = (focus_mode && s2_mix.write_enable) ? s2_tinted : s2_mix.color;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
    if (out_load) begin
      out_mix.color        <= s2_color;
      out_mix.write_enable <= s2_mix.write_enable;
      out_pos              <= s2_pos;
    end
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.pos_x        = out_pos.pos_x;
  assign out_chan.pos_y        = out_pos.pos_y;
  assign out_chan.out_color    = out_mix.color;
  assign out_chan.write_enable = out_mix.write_enable;
  assign out_chan.icon_done    = out_pos.icon_done;

endmodule

`default_nettype wire

// File: hdl/iac_position.sv
`timescale 1ns / 1ps
`default_nettype none

// Column / row counters and screen position of the current pixel.
module iac_position import iac_pkg::*; #(
  parameter int MAX_ICON_DIM = MAX_ICON_DIM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [EDGE_W-1:0] left_pos,
  input  wire logic [EDGE_W-1:0] top_pos,
  input  wire logic [DIM_W-1:0]  icon_width,
  input  wire logic [DIM_W-1:0]  icon_height,
  output pos_t                   pos
);

  localparam int CW = $clog2(MAX_ICON_DIM);
  localparam int EW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam logic [EW-1:0] MAX_DIM = EW'(MAX_ICON_DIM);
  localparam logic [EW-1:0] ONE     = EW'(1);

  logic [CW-1:0] column_count;
  logic [CW-1:0] rows_done;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] rows_done_next;

  logic [EW-1:0] w_raw;
  logic [EW-1:0] h_raw;
  logic [EW-1:0] w;
  logic [EW-1:0] h;
  logic [EW-1:0] col_inc;
  logic [EW-1:0] row_inc;
  logic          row_end;
  logic          last;

  always_comb begin
    w_raw = EW'(icon_width);
    h_raw = EW'(icon_height);
    if (w_raw == '0) begin
      w = ONE;
    end else if (w_raw > MAX_DIM) begin
      w = MAX_DIM;
    end else begin
      w = w_raw;
    end
    if (h_raw == '0) begin
      h = ONE;
    end else if (h_raw > MAX_DIM) begin
      h = MAX_DIM;
    end else begin
      h = h_raw;
    end

    col_inc = EW'(column_count) + ONE;
    row_inc = EW'(rows_done) + ONE;
    row_end = (col_inc >= w);
    last    = row_end && (row_inc >= h);

    // rows arrive bottom first, so the screen row counts down; wraps mod 2048
    pos.pos_x     = POS_W'(left_pos) + POS_W'(column_count);
    pos.pos_y     = POS_W'(top_pos) + POS_W'(h) - POS_W'(1) - POS_W'(rows_done);
    pos.icon_done = last;

    if (last) begin
      column_count_next = '0;
      rows_done_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      rows_done_next    = CW'(row_inc);
    end else begin
      column_count_next = CW'(col_inc);
      rows_done_next    = rows_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_done    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      rows_done    <= rows_done_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/iac_mix.sv
`timescale 1ns / 1ps
`default_nettype none

// Alpha mix of an 8-bit source pixel over an RGB565 background.
module iac_mix import iac_pkg::*; (
  input  wire logic [CH_W-1:0]    src_blue,
  input  wire logic [CH_W-1:0]    src_green,
  input  wire logic [CH_W-1:0]    src_red,
  input  wire logic [CH_W-1:0]    src_alpha,
  input  wire logic [COLOR_W-1:0] back_pixel,
  output mix_t                    mix
);

  // x / 255 for x up to 255*255, exact
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] s;
    s = {1'b0, x} + (2*CH_W+1)'(x[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return s[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] s,
                                            input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] a);
    logic [CH_W-1:0]   na;
    logic [2*CH_W-1:0] ps;
    logic [2*CH_W-1:0] pb;
    logic [CH_W:0]     sum;
    na  = ALPHA_OPAQUE - a;
    ps  = (2*CH_W)'(s) * (2*CH_W)'(a);
    pb  = (2*CH_W)'(b) * (2*CH_W)'(na);
    sum = {1'b0, div255(ps)} + {1'b0, div255(pb)};
    return sum[CH_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] pack565(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g,
                                                 input logic [CH_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic [CH_W-1:0] back_r;
  logic [CH_W-1:0] back_g;
  logic [CH_W-1:0] back_b;

  always_comb begin
    back_r = {back_pixel[15:11], 3'b000};
    back_g = {back_pixel[10:5], 2'b00};
    back_b = {back_pixel[4:0], 3'b000};

    case (src_alpha)
      ALPHA_CLEAR: begin
        mix.color        = back_pixel;
        mix.write_enable = 1'b0;
      end
      ALPHA_OPAQUE: begin
        mix.color        = pack565(src_red, src_green, src_blue);
        mix.write_enable = 1'b1;
      end
      default: begin
        mix.color        = pack565(blend(src_red,   back_r, src_alpha),
                                   blend(src_green, back_g, src_alpha),
                                   blend(src_blue,  back_b, src_alpha));
        mix.write_enable = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/iac_tint.sv
`timescale 1ns / 1ps
`default_nettype none

// Packed 565 blend toward the tint color, weight 10/32, 32-bit wrap.
module iac_tint import iac_pkg::*; (
  input  wire logic [COLOR_W-1:0] base,
  input  wire logic [COLOR_W-1:0] tint,
  output logic      [COLOR_W-1:0] tinted
);

  logic [31:0] a;
  logic [31:0] t;
  logic [31:0] diff;
  logic [31:0] scaled;
  logic [31:0] m;

  always_comb begin
    a      = {base, base} & TINT_MASK;
    t      = {tint, tint} & TINT_MASK;
    diff   = t - a;
    scaled = (diff << 3) + (diff << 1);   // times 10, wraps
    m      = ((scaled >> TINT_SHIFT) + a) & TINT_MASK;
    tinted = m[31:16] | m[15:0];
  end

endmodule

`default_nettype wire
